@@ hdl/kpd_pkg.sv @@
// kpd_pkg: shared types and constants of the keypad scan decoder
// no dependencies; used by kpd_decode and keypad_scan_decode_debounce
package kpd_pkg;

	// keypad layouts selected by the layout register
	typedef enum logic [1:0] {
		LAYOUT_4X4 = 2'd0,
		LAYOUT_5X3 = 2'd1,
		LAYOUT_6X2 = 2'd2,
		LAYOUT_8X1 = 2'd3
	} layout_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_KEY    = 2'd0,
		ST_NOKEY  = 2'd1,
		ST_FAIL   = 2'd2,
		ST_BOUNCE = 2'd3
	} status_t;

	// configuration register indexes
	localparam logic [2:0] REG_LAYOUT   = 3'd0;
	localparam logic [2:0] REG_DEBOUNCE = 3'd1;
	localparam logic [2:0] REG_DEPTH    = 3'd2;
	localparam logic [2:0] REG_MAP_LOW  = 3'd3;
	localparam logic [2:0] REG_MAP_HIGH = 3'd4;

	// decode outcome of one scan
	typedef struct packed {
		logic       nokey;
		logic       fail;
		logic [3:0] key;
	} kpd_dec_t;

endpackage

@@ hdl/kpd_decode.sv @@
// kpd_decode: turns the row and column port bytes into a key number
// depends on kpd_pkg (layout_t, kpd_dec_t)
module kpd_decode
	import kpd_pkg::*;
(
	input  layout_t    layout,
	input  logic [7:0] row_port,
	input  logic [7:0] col_port,
	output kpd_dec_t   dec
);

	localparam logic [4:0] CODE_NOKEY = 5'd16;
	localparam logic [4:0] CODE_FAIL  = 5'd17;

	// position of the single low line inside mask, or no key / fail
	function automatic logic [4:0] one_low(input logic [7:0] v, input logic [7:0] mask,
		input logic [2:0] lsb, input logic [3:0] n);
		logic [4:0] res;
		logic       found;
		res   = CODE_FAIL;
		found = 1'b0;
		if (v == mask) begin
			res   = CODE_NOKEY;
			found = 1'b1;
		end
		for (int i = 0; i < 8; i++) begin
			if (!found && (4'(i) < n) &&
				(v == (mask & ~(8'd1 << (4'(lsb) + 4'(i)))))) begin
				res   = 5'(i);
				found = 1'b1;
			end
		end
		return res;
	endfunction

	logic [7:0] rmask, cmask;
	logic [2:0] rlsb;
	logic [3:0] nrows, ncols;
	logic [4:0] rcode, ccode;
	logic [3:0] col_off;

	// layout geometry
	always_comb begin
		case (layout)
			LAYOUT_5X3: begin
				nrows = 4'd5; rmask = 8'hF8; rlsb = 3'd3; ncols = 4'd3; cmask = 8'h07;
			end
			LAYOUT_6X2: begin
				nrows = 4'd6; rmask = 8'hFC; rlsb = 3'd2; ncols = 4'd2; cmask = 8'h03;
			end
			LAYOUT_8X1: begin
				nrows = 4'd8; rmask = 8'hFF; rlsb = 3'd0; ncols = 4'd0; cmask = 8'h00;
			end
			default: begin
				nrows = 4'd4; rmask = 8'hF0; rlsb = 3'd4; ncols = 4'd4; cmask = 8'h0F;
			end
		endcase
	end

	assign rcode   = one_low(row_port, rmask, rlsb, nrows);
	assign ccode   = one_low(col_port, cmask, 3'd0, ncols);
	assign col_off = 4'(nrows * ccode[1:0]);

	// row byte first; a row no key or fail is final
	always_comb begin
		dec = '0;
		if (rcode == CODE_NOKEY) begin
			dec.nokey = 1'b1;
		end else if (rcode == CODE_FAIL) begin
			dec.fail = 1'b1;
		end else if (ncols == 4'd0) begin
			dec.key = rcode[3:0];
		end else if (ccode == CODE_NOKEY) begin
			dec.nokey = 1'b1;
		end else if (ccode == CODE_FAIL) begin
			dec.fail = 1'b1;
		end else begin
			dec.key = rcode[3:0] + col_off;
		end
	end

endmodule

@@ hdl/keypad_scan_decode_debounce.sv @@
// keypad_scan_decode_debounce: keypad decode, debounce and character history
// depends on kpd_pkg and kpd_decode
// Pipeline: a scan is held in the input register, then the result register
// offers its result.
// Throughput: one scan per cycle unless a result not yet taken stalls it; the
// state update for a scan is done in the cycle it leaves the input register.
// Reset clears configuration, press time, pressed flag and history at once;
// no clearing pass, scans are taken from the first cycle after reset.
module keypad_scan_decode_debounce
	import kpd_pkg::*;
#(
	parameter int HISTORY_MAX = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// scan input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  row_port,
	input  logic [7:0]  col_port,
	input  logic [31:0] now_ms,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [3:0]  key_index,
	output logic [7:0]  key_char,
	output logic        pressed,
	output logic [63:0] history_chars,
	output logic [3:0]  history_length,
	output logic [15:0] press_length_ms
);

	// configuration registers
	layout_t     layout_q;
	logic [7:0]  debounce_q;
	logic [3:0]  depth_q;
	logic [63:0] map_low_q, map_high_q;

	// block state
	logic [31:0] last_press_q;
	logic        pressed_q;
	logic [7:0]  hist_q [HISTORY_MAX];
	logic [3:0]  hist_cnt_q;

	// input stage
	logic        valid_s1;
	logic [7:0]  row_s1, col_s1;
	logic [31:0] now_s1;

	// result register
	logic        res_valid_q;
	status_t     res_status_q;
	logic [3:0]  res_key_q;
	logic [7:0]  res_char_q;
	logic        res_pressed_q;
	logic [63:0] res_hist_q;
	logic [3:0]  res_len_q;
	logic [15:0] res_plen_q;

	// next state and result values
	kpd_dec_t    dec;
	logic        advance;
	logic [31:0] elapsed;
	logic        bounce, take_key, shift;
	logic [3:0]  depth_sat;
	logic [63:0] map_word;
	logic [7:0]  ch;
	status_t     nxt_status;
	logic        nxt_pressed;
	logic [3:0]  nxt_cnt;
	logic [7:0]  ins_hist [HISTORY_MAX];
	logic [7:0]  nxt_hist [HISTORY_MAX];
	logic [63:0] nxt_hist_word;

	assign advance  = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	kpd_decode u_decode (
		.layout   (layout_q),
		.row_port (row_s1),
		.col_port (col_s1),
		.dec      (dec)
	);

	// debounce window and character lookup
	assign elapsed   = now_s1 - last_press_q;
	assign bounce    = elapsed < {24'd0, debounce_q};
	assign depth_sat = (depth_q > 4'(HISTORY_MAX)) ? 4'(HISTORY_MAX) : depth_q;
	assign map_word  = dec.key[3] ? map_high_q : map_low_q;
	assign ch        = map_word[{dec.key[2:0], 3'b000} +: 8];
	assign take_key  = !dec.nokey && !bounce && !dec.fail && (depth_sat != 4'd0);
	assign shift     = hist_cnt_q >= depth_sat;

	// status
	always_comb begin
		if (dec.nokey) begin
			nxt_status = ST_NOKEY;
		end else if (bounce) begin
			nxt_status = ST_BOUNCE;
		end else if (dec.fail) begin
			nxt_status = ST_FAIL;
		end else begin
			nxt_status = ST_KEY;
		end
	end

	// history append, dropping the oldest when over depth
	always_comb begin
		for (int i = 0; i < HISTORY_MAX; i++) begin
			ins_hist[i] = (4'(i) == hist_cnt_q) ? ch : hist_q[i];
		end
		for (int i = 0; i < HISTORY_MAX; i++) begin
			if (!take_key) begin
				nxt_hist[i] = hist_q[i];
			end else if (!shift) begin
				nxt_hist[i] = ins_hist[i];
			end else if (i < HISTORY_MAX - 1) begin
				nxt_hist[i] = ins_hist[i + 1];
			end else begin
				nxt_hist[i] = (hist_cnt_q >= 4'(HISTORY_MAX)) ? ch : 8'd0;
			end
		end
		nxt_cnt = (take_key && !shift) ? hist_cnt_q + 4'd1 : hist_cnt_q;
		nxt_pressed = dec.nokey ? 1'b0 : (take_key ? 1'b1 : pressed_q);
		nxt_hist_word = '0;
		for (int i = 0; i < HISTORY_MAX; i++) begin
			if (4'(i) < nxt_cnt) begin
				nxt_hist_word[8*i +: 8] = nxt_hist[i];
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q   <= LAYOUT_4X4;
			debounce_q <= '0;
			depth_q    <= '0;
			map_low_q  <= '0;
			map_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LAYOUT:   layout_q   <= layout_t'(cfg_data[1:0]);
				REG_DEBOUNCE: debounce_q <= cfg_data[7:0];
				REG_DEPTH:    depth_q    <= cfg_data[3:0];
				REG_MAP_LOW:  map_low_q  <= cfg_data;
				REG_MAP_HIGH: map_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// state update and handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_q  <= 1'b0;
			last_press_q <= '0;
			pressed_q    <= 1'b0;
			hist_cnt_q   <= '0;
			for (int i = 0; i < HISTORY_MAX; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
			if (advance) begin
				if (take_key) begin
					last_press_q <= now_s1;
				end
				pressed_q  <= nxt_pressed;
				hist_cnt_q <= nxt_cnt;
				for (int i = 0; i < HISTORY_MAX; i++) begin
					hist_q[i] <= nxt_hist[i];
				end
			end
		end
	end

	// input and result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			row_s1 <= row_port;
			col_s1 <= col_port;
			now_s1 <= now_ms;
		end
		if (advance) begin
			res_status_q  <= nxt_status;
			res_key_q     <= (dec.nokey || dec.fail) ? 4'd0 : dec.key;
			res_char_q    <= (dec.nokey || dec.fail) ? 8'd0 : ch;
			res_pressed_q <= nxt_pressed;
			res_hist_q    <= nxt_hist_word;
			res_len_q     <= nxt_cnt;
			res_plen_q    <= take_key ? 16'd0 : elapsed[15:0];
		end
	end

	assign out_valid       = res_valid_q;
	assign status          = res_status_q;
	assign key_index       = res_key_q;
	assign key_char        = res_char_q;
	assign pressed         = res_pressed_q;
	assign history_chars   = res_hist_q;
	assign history_length  = res_len_q;
	assign press_length_ms = res_plen_q;

	// history never holds more than its storage
	a_hist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hist_cnt_q <= 4'(HISTORY_MAX))
		else $error("history count beyond storage");

	// history only moves when a scan leaves the input register
	a_hist_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(hist_cnt_q) && $stable(last_press_q))
		else $error("state changed without a scan");

	// no-key result always reports released
	a_nokey_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NOKEY |-> !pressed)
		else $error("no-key result with pressed flag");

	// an empty input register always takes a transfer
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while empty");

endmodule

@@ bench/keypad_scan_decode_debounce_test.sv @@
// keypad_scan_decode_debounce_test: self-checking bench for the keypad scan decoder
// drives scans and register writes, predicts every result and checks it in order
// depends on kpd_pkg and keypad_scan_decode_debounce
module keypad_scan_decode_debounce_test;
	import kpd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HISTORY_MAX = 8;
	localparam logic [4:0] CODE_NOKEY = 5'd16;
	localparam logic [4:0] CODE_FAIL  = 5'd17;

	// one predicted result
	typedef struct packed {
		status_t     status;
		logic [3:0]  key_index;
		logic [7:0]  key_char;
		logic        pressed;
		logic [63:0] history_chars;
		logic [3:0]  history_length;
		logic [15:0] press_length_ms;
	} scan_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  row_port;
	logic [7:0]  col_port;
	logic [31:0] now_ms;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [3:0]  key_index;
	logic [7:0]  key_char;
	logic        pressed;
	logic [63:0] history_chars;
	logic [3:0]  history_length;
	logic [15:0] press_length_ms;

	// register copies held by the predictor
	layout_t     layout_sel   = LAYOUT_4X4;
	logic [7:0]  debounce_win = '0;
	logic [3:0]  log_depth    = '0;
	logic [63:0] keymap_lo    = '0;
	logic [63:0] keymap_hi    = '0;

	// predictor state; the extra entry takes a character before the oldest is dropped
	logic [31:0] press_time  = '0;
	logic        key_pressed = 1'b0;
	logic [7:0]  char_log [HISTORY_MAX + 1] = '{default: 8'd0};
	int          char_count  = 0;

	scan_result_t results_due [$];
	int           mismatch_count = 0;
	int           send_idle_pct  = 0;
	int           recv_idle_pct  = 0;
	logic [31:0]  scan_clock     = '0;

	keypad_scan_decode_debounce #(
		.HISTORY_MAX(HISTORY_MAX)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.row_port       (row_port),
		.col_port       (col_port),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.key_index      (key_index),
		.key_char       (key_char),
		.pressed        (pressed),
		.history_chars  (history_chars),
		.history_length (history_length),
		.press_length_ms(press_length_ms)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// row and column line sets of each layout
	function automatic void layout_geometry(input layout_t lay, output int nrows,
			output logic [7:0] rmask, output int ncols, output logic [7:0] cmask);
		case (lay)
			LAYOUT_5X3: begin
				nrows = 5; rmask = 8'hF8; ncols = 3; cmask = 8'h07;
			end
			LAYOUT_6X2: begin
				nrows = 6; rmask = 8'hFC; ncols = 2; cmask = 8'h03;
			end
			LAYOUT_8X1: begin
				nrows = 8; rmask = 8'hFF; ncols = 0; cmask = 8'h00;
			end
			default: begin
				nrows = 4; rmask = 8'hF0; ncols = 4; cmask = 8'h0F;
			end
		endcase
	endfunction

	// position of the one low line, or no key / fail
	function automatic logic [4:0] single_low_line(logic [7:0] v, logic [7:0] mask,
			int lsb, int n);
		logic [4:0] code;
		int         i;
		code = CODE_FAIL;
		if (v == mask) begin
			code = CODE_NOKEY;
		end else begin
			for (i = 0; i < n; i++)
				if (v == (mask & ~(8'd1 << (lsb + i))))
					code = 5'(i);
		end
		return code;
	endfunction

	// row byte first; a no key or fail there is final
	function automatic logic [4:0] decode_scan(logic [7:0] rowb, logic [7:0] colb);
		int         nrows, ncols;
		logic [7:0] rmask, cmask;
		logic [4:0] r, c;
		layout_geometry(layout_sel, nrows, rmask, ncols, cmask);
		r = single_low_line(rowb, rmask, 8 - nrows, nrows);
		if (r >= CODE_NOKEY || ncols == 0)
			return r;
		c = single_low_line(colb, cmask, 0, ncols);
		if (c >= CODE_NOKEY)
			return c;
		return 5'(int'(r) + nrows * int'(c));
	endfunction

	function automatic logic [7:0] key_character(logic [3:0] k);
		return k[3] ? keymap_hi[k[2:0] * 8 +: 8] : keymap_lo[k[2:0] * 8 +: 8];
	endfunction

	// decode, debounce and history update of one scan
	function automatic scan_result_t next_scan_result(logic [7:0] rowb, logic [7:0] colb,
			logic [31:0] now);
		scan_result_t res;
		logic [4:0]   code;
		logic [7:0]   ch;
		int           depth, i;
		res  = '0;
		code = decode_scan(rowb, colb);
		ch   = (code < CODE_NOKEY) ? key_character(code[3:0]) : 8'd0;
		depth = (log_depth > HISTORY_MAX) ? HISTORY_MAX : int'(log_depth);
		if (code == CODE_NOKEY) begin
			key_pressed = 1'b0;
			res.status  = ST_NOKEY;
		end else if (now - press_time < {24'd0, debounce_win}) begin
			res.status = ST_BOUNCE;
		end else if (code >= CODE_NOKEY) begin
			res.status = ST_FAIL;
		end else begin
			res.status = ST_KEY;
			if (depth != 0) begin
				press_time  = now;
				key_pressed = 1'b1;
				char_log[char_count] = ch;
				char_count++;
				// over depth or full: drop the oldest character
				if (char_count > depth) begin
					for (i = 0; i < HISTORY_MAX; i++)
						char_log[i] = char_log[i + 1];
					char_log[HISTORY_MAX] = 8'd0;
					char_count--;
				end
			end
		end
		for (i = 0; i < char_count; i++)
			res.history_chars[8 * i +: 8] = char_log[i];
		res.key_index       = (code < CODE_NOKEY) ? code[3:0] : 4'd0;
		res.key_char        = ch;
		res.pressed         = key_pressed;
		res.history_length  = 4'(char_count);
		res.press_length_ms = 16'(now - press_time);
		return res;
	endfunction

	// one scan transfer; returns at the falling edge after it
	task automatic send_scan(input logic [7:0] rowb, input logic [7:0] colb,
			input logic [31:0] now);
		scan_result_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		row_port <= rowb;
		col_port <= colb;
		now_ms   <= now;
		do
			@(posedge clk);
		while (!in_ready);
		res = next_scan_result(rowb, colb, now);
		@(negedge clk);
		results_due.push_back(res);
	endtask

	// stop sending and let every outstanding result arrive
	task automatic wait_for_drain();
		int cycles;
		cycles = 0;
		in_valid <= 1'b0;
		while (results_due.size() != 0 && cycles < 20000) begin
			@(negedge clk);
			cycles++;
		end
		repeat (4) @(negedge clk);
	endtask

	// register write; only called with the block idle
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		case (idx)
			REG_LAYOUT:   layout_sel   = layout_t'(value[1:0]);
			REG_DEBOUNCE: debounce_win = value[7:0];
			REG_DEPTH:    log_depth    = value[3:0];
			REG_MAP_LOW:  keymap_lo    = value;
			REG_MAP_HIGH: keymap_hi    = value;
			default: ;
		endcase
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			mismatch_count++;
		end
	endfunction

	// result check against the oldest prediction
	always @(posedge clk) begin : check_results
		scan_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: result transfer with nothing expected, expected none, actual %0h",
					$time, status);
				mismatch_count++;
			end else begin
				want = results_due.pop_front();
				compare_field("status", 64'(want.status), 64'(status));
				compare_field("key_index", 64'(want.key_index), 64'(key_index));
				compare_field("key_char", 64'(want.key_char), 64'(key_char));
				compare_field("pressed", 64'(want.pressed), 64'(pressed));
				compare_field("history_chars", want.history_chars, history_chars);
				compare_field("history_length", 64'(want.history_length), 64'(history_length));
				compare_field("press_length_ms", 64'(want.press_length_ms),
					64'(press_length_ms));
			end
		end
	end

	// receiver stalls
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// reset values: 4x4, no debounce, no history, empty maps
	task automatic test_after_reset();
		send_scan(8'hE0, 8'h0E, 32'd5);
		send_scan(8'hF0, 8'h3C, 32'd6);
		send_scan(8'h00, 8'hFF, 32'd7);
	endtask

	// extreme keys of every layout, column fail and column no key
	task automatic test_layouts();
		wait_for_drain();
		write_reg(REG_DEPTH, 64'd8);
		write_reg(REG_MAP_LOW, 64'h3736_3534_3332_3130);
		write_reg(REG_MAP_HIGH, 64'hFF46_4544_4342_4100);
		send_scan(8'h70, 8'h07, 32'd100);
		send_scan(8'hE0, 8'h0C, 32'd110);
		send_scan(8'hE0, 8'h0F, 32'd120);
		wait_for_drain();
		write_reg(REG_LAYOUT, 64'(LAYOUT_5X3));
		send_scan(8'h78, 8'h03, 32'd130);
		wait_for_drain();
		write_reg(REG_LAYOUT, 64'(LAYOUT_6X2));
		send_scan(8'h7C, 8'h01, 32'd140);
		wait_for_drain();
		// column byte plays no part in 8x1
		write_reg(REG_LAYOUT, 64'(LAYOUT_8X1));
		send_scan(8'h7F, 8'h5A, 32'd150);
	endtask

	// widest window: bounce on a key and on a fail, edge of window, time wrap
	task automatic test_debounce();
		wait_for_drain();
		write_reg(REG_LAYOUT, 64'(LAYOUT_4X4));
		write_reg(REG_DEBOUNCE, 64'd255);
		send_scan(8'hD0, 8'h0D, 32'd10000);
		send_scan(8'hB0, 8'h0B, 32'd10254);
		send_scan(8'h00, 8'h00, 32'd10100);
		send_scan(8'hB0, 8'h0B, 32'd10255);
		send_scan(8'h70, 8'h0E, 32'hFFFF_FF80);
		send_scan(8'hE0, 8'h07, 32'h0000_0010);
		send_scan(8'hF0, 8'h0F, 32'h0000_0020);
	endtask

	// full history, depth lowered, depth above the maximum, recording off
	task automatic test_history_depth();
		wait_for_drain();
		write_reg(REG_DEBOUNCE, 64'd0);
		send_scan(8'hE0, 8'h0D, 32'h0000_0100);
		send_scan(8'hD0, 8'h0E, 32'h0000_0200);
		wait_for_drain();
		write_reg(REG_DEPTH, 64'd2);
		send_scan(8'hB0, 8'h07, 32'h0000_0300);
		wait_for_drain();
		write_reg(REG_DEPTH, 64'd12);
		send_scan(8'h70, 8'h0B, 32'h0000_0400);
		wait_for_drain();
		write_reg(REG_DEPTH, 64'd0);
		send_scan(8'hE0, 8'h0E, 32'h0000_0500);
	endtask

	// mostly clean key presses at random times, with idle scans and corrupted bytes
	task automatic send_random_scan();
		int         nrows, ncols, pick;
		logic [7:0] rmask, cmask, rowb, colb;
		layout_geometry(layout_sel, nrows, rmask, ncols, cmask);
		rowb = rmask & ~(8'd1 << (8 - nrows + int'($urandom_range(0, nrows - 1))));
		colb = (ncols != 0) ? (cmask & ~(8'd1 << $urandom_range(0, ncols - 1)))
			: 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 10)
			rowb = rmask;
		else if (pick < 15)
			colb = cmask;
		else if (pick < 25)
			rowb ^= 8'd1 << $urandom_range(0, 7);
		else if (pick < 30)
			colb ^= 8'd1 << $urandom_range(0, 7);
		else if (pick < 35) begin
			rowb = 8'($urandom);
			colb = 8'($urandom);
		end
		// time mostly moves around the debounce window, sometimes far
		pick = $urandom_range(0, 99);
		if (pick < 80)
			scan_clock += $urandom_range(0, 2 * int'(debounce_win) + 2);
		else if (pick < 92)
			scan_clock += $urandom_range(0, 150000);
		else if (pick < 97)
			scan_clock = $urandom;
		send_scan(rowb, colb, scan_clock);
	endtask

	// three stall patterns, each with several random register settings
	task automatic test_random_traffic();
		int phase, batch, n;
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 70 : 0;
			recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 7 : 0;
			for (batch = 0; batch < 4; batch++) begin
				wait_for_drain();
				write_reg(REG_LAYOUT, 64'($urandom_range(0, 3)));
				case ($urandom_range(0, 3))
					0:       write_reg(REG_DEBOUNCE, 64'd0);
					1:       write_reg(REG_DEBOUNCE, 64'd255);
					default: write_reg(REG_DEBOUNCE, 64'($urandom_range(1, 40)));
				endcase
				if ($urandom_range(0, 7) == 0)
					write_reg(REG_DEPTH, 64'($urandom_range(9, 15)));
				else
					write_reg(REG_DEPTH, 64'($urandom_range(0, 8)));
				write_reg(REG_MAP_LOW, {$urandom, $urandom});
				write_reg(REG_MAP_HIGH, {$urandom, $urandom});
				for (n = 0; n < 100; n++)
					send_random_scan();
			end
		end
	endtask

	// sequence of tests and final verdict
	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_LAYOUT;
		cfg_data  = '0;
		in_valid  = 1'b0;
		row_port  = '0;
		col_port  = '0;
		now_ms    = '0;
		send_idle_pct = 7;
		recv_idle_pct = 70;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_after_reset();
		test_layouts();
		test_debounce();
		test_history_depth();
		test_random_traffic();
		wait_for_drain();
		repeat (8) @(negedge clk);
		if (results_due.size() != 0) begin
			$display("%0t: results never delivered, expected %0d more, actual 0",
				$time, results_due.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("keypad_scan_decode_debounce regression: pass");
		else
			$display("keypad_scan_decode_debounce regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#400000;
		$display("keypad_scan_decode_debounce regression: fail");
		$finish;
	end

endmodule

@@ files.f @@
hdl/kpd_pkg.sv
hdl/kpd_decode.sv
hdl/keypad_scan_decode_debounce.sv
bench/keypad_scan_decode_debounce_test.sv
